@@ design/stc_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and breakpoint table for the speed throttle controller.
package stc_pkg;

  localparam int HISTORY_DEPTH = 9;
  localparam int TABLE_ENTRIES = 16;
  localparam int BP_COUNT      = 16;
  localparam int BP_USED       = (TABLE_ENTRIES < BP_COUNT) ? TABLE_ENTRIES : BP_COUNT;
  localparam int BP_IDX_W      = $clog2(BP_COUNT);

  localparam int SPEED_W       = 13;
  localparam int TARGET_W      = 11;
  localparam int GAIN_W        = 8;
  localparam int THR_W         = 8;
  localparam int FRAC_BITS     = 12;
  localparam int THROTTLE_STEP = 10;

  localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W         = $clog2(HISTORY_DEPTH * (1 << (SPEED_W - 1)) + 1) + 1;

  // shared divider: 24-bit dividend, 8-bit divisor, 16 quotient bits
  localparam int DVD_W         = 24;
  localparam int DVS_W         = 8;
  localparam int QUO_W         = DVD_W - DVS_W;
  localparam int STEP_CNT_W    = $clog2(QUO_W);

  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;
  localparam int REG_IDX_W     = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_GAIN     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW_THR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH_THR = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_THR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_THR  = 3'd4;

  localparam logic [TARGET_W-1:0] BP_TABLE [BP_COUNT] = '{
    11'd0,    11'd128,  11'd256,  11'd333,  11'd410,  11'd512,  11'd614,  11'd666,
    11'd870,  11'd973,  11'd1101, 11'd1203, 11'd1357, 11'd1434, 11'd1485, 11'd1536
  };

  typedef struct packed {
    logic [GAIN_W-1:0]   gain;
    logic [TARGET_W-1:0] low_thr;
    logic [TARGET_W-1:0] high_thr;
    logic [THR_W-1:0]    min_thr;
    logic [THR_W-1:0]    max_thr;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    gain:     8'd160,
    low_thr:  11'd26,
    high_thr: 11'd1510,
    min_thr:  8'd100,
    max_thr:  8'd250
  };

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ design/stc_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: speed samples and throttle requests.
interface stc_in_if;
  import stc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic signed [SPEED_W-1:0]  speed_sample;
  logic [TARGET_W-1:0]        set_speed;

  modport source (output valid, operation, speed_sample, set_speed, input ready);
  modport sink   (input valid, operation, speed_sample, set_speed, output ready);
endinterface

@@ design/stc_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: saturated throttle command and clip flag.
interface stc_out_if;
  import stc_pkg::*;

  logic             valid;
  logic             ready;
  logic [THR_W-1:0] throttle_command;
  logic             clipped;

  modport source (output valid, throttle_command, clipped, input ready);
  modport sink   (input valid, throttle_command, clipped, output ready);
endinterface

@@ design/stc_apb_regs.sv @@
`timescale 1ns / 1ps
// APB configuration register file.
module stc_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [stc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [stc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output stc_pkg::cfg_t                  cfg
);
  import stc_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_GAIN:     cfg.gain     <= pwdata[GAIN_W-1:0];
        REG_LOW_THR:  cfg.low_thr  <= pwdata[TARGET_W-1:0];
        REG_HIGH_THR: cfg.high_thr <= pwdata[TARGET_W-1:0];
        REG_MIN_THR:  cfg.min_thr  <= pwdata[THR_W-1:0];
        REG_MAX_THR:  cfg.max_thr  <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_GAIN:     prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, cfg.gain};
      REG_LOW_THR:  prdata = {{(APB_DATA_W-TARGET_W){1'b0}}, cfg.low_thr};
      REG_HIGH_THR: prdata = {{(APB_DATA_W-TARGET_W){1'b0}}, cfg.high_thr};
      REG_MIN_THR:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, cfg.min_thr};
      REG_MAX_THR:  prdata = {{(APB_DATA_W-THR_W){1'b0}}, cfg.max_thr};
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/stc_divider.sv @@
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
module stc_divider (
  input  logic              clk,
  input  logic              rst,
  input  stc_pkg::div_req_t req,
  output stc_pkg::div_rsp_t rsp
);
  import stc_pkg::*;

  logic                  busy;
  logic                  done;
  logic [STEP_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]      rem;
  logic [DVS_W-1:0]      divisor_q;
  logic [QUO_W-1:0]      shreg;

  logic [DVS_W:0]        trial;
  logic [DVS_W:0]        trial_diff;
  logic                  fits;
  logic [DVS_W-1:0]      rem_next;

  // remainder stays below the divisor, so one subtract per bit suffices
  assign trial      = {rem, shreg[QUO_W-1]};
  assign trial_diff = trial - {1'b0, divisor_q};
  assign fits       = (trial >= {1'b0, divisor_q});
  assign rem_next   = fits ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_CNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem       <= req.dividend[DVD_W-1:QUO_W];
      shreg     <= req.dividend[QUO_W-1:0];
      divisor_q <= req.divisor;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[QUO_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = shreg;

endmodule

@@ design/speed_throttle_controller_unit.sv @@
`timescale 1ns / 1ps
// Speed throttle controller top level: sequencer, history, feed-forward and saturation.
//
//  channel  | dir | transfer                   | payload
//  ---------+-----+----------------------------+------------------------------------------
//  in_ch    | in  | valid & ready              | operation, speed_sample, set_speed
//  out_ch   | out | valid & ready              | throttle_command, clipped
//  apb      | in  | psel & penable & pwrite    | paddr, pwdata (prdata on reads)
//
// Sample item: S_ACC sums the history, S_SETUP starts the shared divider, and S_DIV waits
//   for the average; the history then shifts in the sample.
// Target item: S_SETUP to S_OUT outside the thresholds or table range, else through the divider.
// in_ch.ready is high only between items; a held result does not block the next transfer in.
// Synchronous reset restores registers, history and average to their reset values.
module speed_throttle_controller_unit (
  input  logic                           clk,
  input  logic                           rst,
  stc_in_if.sink                         in_ch,
  stc_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [stc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [stc_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import stc_pkg::*;

  localparam int DIFF_W  = SPEED_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
  localparam int BASE_W  = THR_W + 1;
  localparam int FF_W    = BASE_W + FRAC_BITS + 1;
  localparam int RAW_W   = PROD_W + 1;
  localparam int STEPN_W = TARGET_W + 4;

  typedef enum logic [2:0] {S_IDLE, S_ACC, S_SETUP, S_DIV, S_OUT} state_t;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_t                     state;
  logic                       op_target;
  logic signed [SPEED_W-1:0]  sample;
  logic [TARGET_W-1:0]        target;
  logic signed [SPEED_W-1:0]  hist [HISTORY_DEPTH];
  logic [HIST_IDX_W-1:0]      idx;
  logic signed [SUM_W-1:0]    acc;
  logic signed [SPEED_W-1:0]  avg;
  logic signed [PROD_W-1:0]   prod;
  logic [FF_W-1:0]            ff;
  logic                       out_valid;
  logic [THR_W-1:0]           out_cmd;
  logic                       out_clip;

  logic                       acc_neg;
  logic [SUM_W-1:0]           acc_abs;
  logic [SPEED_W-1:0]         avg_mag;
  logic                       seg_hit;
  logic [BP_IDX_W-1:0]        seg;
  logic [TARGET_W-1:0]        bp_lo;
  logic [TARGET_W-1:0]        bp_hi;
  logic [TARGET_W-1:0]        offs;
  logic [TARGET_W-1:0]        bp_span;
  logic [STEPN_W-1:0]         step_num;
  logic [BASE_W-1:0]          base;
  logic [BASE_W-1:0]          end_base;
  logic                       t_low;
  logic                       t_high;
  logic                       interp;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [RAW_W-1:0]    raw;
  logic                       raw_over;
  logic [THR_W-1:0]           cmd;
  logic                       clip;
  logic                       in_xfer;

  stc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid & in_ch.ready;

  // history sum magnitude for the divide
  assign acc_neg = acc[SUM_W-1];
  assign acc_abs = acc_neg ? -acc : acc;
  assign avg_mag = div_rsp.quotient[SPEED_W-1:0];

  // interval search: first segment whose upper breakpoint is not below the target
  always_comb begin
    seg_hit = 1'b0;
    seg     = '0;
    for (int k = BP_USED - 2; k >= 0; k--) begin
      if (target <= BP_TABLE[k+1]) begin
        seg_hit = 1'b1;
        seg     = BP_IDX_W'(k);
      end
    end
  end

  assign bp_lo    = BP_TABLE[seg];
  assign bp_hi    = BP_TABLE[seg + 1'b1];
  assign offs     = target - bp_lo;
  assign bp_span  = bp_hi - bp_lo;
  assign step_num = STEPN_W'(offs) * STEPN_W'(THROTTLE_STEP);
  assign base     = {1'b0, cfg.min_thr} + BASE_W'(seg) * BASE_W'(THROTTLE_STEP);
  assign end_base = {1'b0, cfg.min_thr} + BASE_W'(THROTTLE_STEP * (BP_USED - 1));

  assign t_low  = (target < cfg.low_thr);
  assign t_high = (target > cfg.high_thr);
  assign interp = !t_low && !t_high && seg_hit;

  assign diff      = $signed({{(DIFF_W-TARGET_W){1'b0}}, target}) - {avg[SPEED_W-1], avg};
  assign prod_next = $signed({1'b0, cfg.gain}) * diff;

  always_comb begin
    div_req.start = (state == S_SETUP) && (!op_target || interp);
    if (op_target) begin
      div_req.dividend = {step_num[DVD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      div_req.divisor  = bp_span[DVS_W-1:0];
    end else begin
      div_req.dividend = {{(DVD_W-SUM_W+1){1'b0}}, acc_abs[SUM_W-2:0]};
      div_req.divisor  = DVS_W'(HISTORY_DEPTH);
    end
  end

  // saturation of feed-forward plus proportional term
  assign raw      = $signed({{(RAW_W-FF_W){1'b0}}, ff}) + {prod[PROD_W-1], prod};
  assign raw_over = !raw[RAW_W-1] && (raw[RAW_W-2:FRAC_BITS+THR_W] != '0);

  always_comb begin
    clip = 1'b0;
    cmd  = raw[FRAC_BITS+THR_W-1:FRAC_BITS];
    if (raw[RAW_W-1]) begin
      clip = 1'b1;
      cmd  = '0;
    end else if (raw_over) begin
      clip = 1'b1;
      cmd  = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op_target <= 1'b0;
      idx       <= '0;
      acc       <= '0;
      avg       <= '0;
      out_valid <= 1'b0;
      for (int k = 0; k < HISTORY_DEPTH; k++) begin
        hist[k] <= '0;
      end
    end else begin
      // S_OUT loads the output register itself
      if (out_valid && out_ch.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op_target <= in_ch.operation;
            sample    <= in_ch.speed_sample;
            target    <= in_ch.set_speed;
            acc       <= '0;
            idx       <= '0;
            state     <= in_ch.operation ? S_SETUP : S_ACC;
          end
        end
        S_ACC: begin
          acc <= acc + SUM_W'(hist[idx]);
          idx <= idx + 1'b1;
          if (idx == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (op_target) begin
            prod <= prod_next;
            if (t_low) begin
              ff    <= FF_W'({cfg.min_thr, {FRAC_BITS{1'b0}}});
              state <= S_OUT;
            end else if (t_high) begin
              ff    <= FF_W'({cfg.max_thr, {FRAC_BITS{1'b0}}});
              state <= S_OUT;
            end else if (!seg_hit) begin
              ff    <= FF_W'({end_base, {FRAC_BITS{1'b0}}});
              state <= S_OUT;
            end else begin
              state <= S_DIV;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (op_target) begin
              ff    <= FF_W'({base, {FRAC_BITS{1'b0}}}) + FF_W'(div_rsp.quotient);
              state <= S_OUT;
            end else begin
              avg <= acc_neg ? -avg_mag : avg_mag;
              for (int k = 0; k < HISTORY_DEPTH - 1; k++) begin
                hist[k] <= hist[k+1];
              end
              hist[HISTORY_DEPTH-1] <= sample;
              state <= S_IDLE;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_cmd   <= cmd;
            out_clip  <= clip;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.throttle_command = out_cmd;
  assign out_ch.clipped          = out_clip;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV)
    else $error("divider finished outside the divide wait");

  a_sample_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !in_ch.operation && !out_valid) |=> !out_valid)
    else $error("speed sample produced a result");

  a_clip_rails: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_clip) |-> (out_cmd == '0 || out_cmd == '1))
    else $error("clipped result not at a rail");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the speed throttle controller: directed and random transfers.
module testbench;
  import stc_pkg::*;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  localparam int TARGET_MAX     = (1 << TARGET_W) - 1;
  localparam int DRAIN_CYCLES   = 64;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 50;
  localparam int STALL_PHASE    = 3;
  localparam int PAUSE_PHASE    = 5;

  typedef struct {
    logic                      operation;
    logic signed [SPEED_W-1:0] speed_sample;
    logic [TARGET_W-1:0]       set_speed;
  } speed_item_t;

  typedef struct {
    logic [THR_W-1:0] throttle_command;
    logic             clipped;
  } throttle_result_t;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_CADENCE} rx_pattern_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  stc_in_if  in_ch ();
  stc_out_if out_ch ();

  speed_throttle_controller_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's settings and history
  cfg_t                      shadow_cfg;
  logic signed [SPEED_W-1:0] speed_hist [HISTORY_DEPTH];
  logic signed [SPEED_W-1:0] avg_speed;

  speed_item_t      pending_items [$];
  throttle_result_t expected_throttle [$];

  int error_count    = 0;
  int stall_requests = 0;
  bit sender_hold    = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void absorb_speed_sample(logic signed [SPEED_W-1:0] sample);
    int total = 0;
    foreach (speed_hist[k]) total += speed_hist[k];
    avg_speed = SPEED_W'(total / HISTORY_DEPTH);
    for (int k = 0; k + 1 < HISTORY_DEPTH; k++) speed_hist[k] = speed_hist[k + 1];
    speed_hist[HISTORY_DEPTH - 1] = sample;
  endfunction

  function automatic void predict_throttle(logic [TARGET_W-1:0] tgt);
    longint           t;
    longint           ff;
    longint           raw;
    longint           lo;
    longint           hi;
    bit               found = 1'b0;
    throttle_result_t res;
    t = longint'(tgt);
    if (t < longint'(shadow_cfg.low_thr)) begin
      ff = longint'(shadow_cfg.min_thr) << FRAC_BITS;
    end else if (t > longint'(shadow_cfg.high_thr)) begin
      ff = longint'(shadow_cfg.max_thr) << FRAC_BITS;
    end else begin
      ff = (longint'(shadow_cfg.min_thr) + THROTTLE_STEP * (BP_USED - 1)) << FRAC_BITS;
      for (int seg = 0; seg + 1 < BP_USED; seg++) begin
        lo = longint'(BP_TABLE[seg]);
        hi = longint'(BP_TABLE[seg + 1]);
        if (!found && lo <= t && t <= hi) begin
          found = 1'b1;
          ff = ((longint'(shadow_cfg.min_thr) + THROTTLE_STEP * seg) << FRAC_BITS)
             + ((THROTTLE_STEP * (t - lo)) << FRAC_BITS) / (hi - lo);
        end
      end
    end
    raw = ff + longint'(shadow_cfg.gain) * (t - longint'(avg_speed));
    if (raw < 0) begin
      res.throttle_command = '0;
      res.clipped          = 1'b1;
    end else if (raw >= (longint'(256) << FRAC_BITS)) begin
      res.throttle_command = '1;
      res.clipped          = 1'b1;
    end else begin
      res.throttle_command = THR_W'(raw >> FRAC_BITS);
      res.clipped          = 1'b0;
    end
    expected_throttle = {expected_throttle, res};
  endfunction

  // driver: bursts of transfers separated by random gaps
  int          burst_left;
  int          gap_left;
  speed_item_t offer;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_SAMPLE) absorb_speed_sample(in_ch.speed_sample);
        else predict_throttle(in_ch.set_speed);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() != 0 && !sender_hold) begin
          offer = pending_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.operation    <= offer.operation;
          in_ch.speed_sample <= offer.speed_sample;
          in_ch.set_speed    <= offer.set_speed;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results and stalls the output on its own pattern
  int               stall_served = 0;
  int               hold_left    = 0;
  int               pattern_left = 0;
  int               beat         = 0;
  rx_pattern_t      rx_mode      = RX_FREE;
  throttle_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_throttle.size() == 0) begin
          $error("unexpected result: throttle_command %0d clipped %0b",
                 out_ch.throttle_command, out_ch.clipped);
          error_count++;
        end else begin
          want = expected_throttle.pop_front();
          if (out_ch.throttle_command !== want.throttle_command) begin
            $error("throttle_command: expected %0d, got %0d",
                   want.throttle_command, out_ch.throttle_command);
            error_count++;
          end
          if (out_ch.clipped !== want.clipped) begin
            $error("clipped: expected %0b, got %0b", want.clipped, out_ch.clipped);
            error_count++;
          end
        end
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_left    = LONG_HOLD;
      end
      if (pattern_left == 0) begin
        rx_mode      = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 96);
      end else begin
        pattern_left--;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_COIN:   out_ch.ready <= $urandom_range(0, 1);
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= (beat % 5 != 0);
        endcase
      end
    end
  end

  // watchdog: cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    logic [APB_DATA_W-1:0] data;
    data = $urandom;
    case (idx)
      REG_GAIN:     data[GAIN_W-1:0]   = value[GAIN_W-1:0];
      REG_LOW_THR:  data[TARGET_W-1:0] = value[TARGET_W-1:0];
      REG_HIGH_THR: data[TARGET_W-1:0] = value[TARGET_W-1:0];
      REG_MIN_THR:  data[THR_W-1:0]    = value[THR_W-1:0];
      REG_MAX_THR:  data[THR_W-1:0]    = value[THR_W-1:0];
      default:      data = data;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN:     shadow_cfg.gain     = data[GAIN_W-1:0];
      REG_LOW_THR:  shadow_cfg.low_thr  = data[TARGET_W-1:0];
      REG_HIGH_THR: shadow_cfg.high_thr = data[TARGET_W-1:0];
      REG_MIN_THR:  shadow_cfg.min_thr  = data[THR_W-1:0];
      REG_MAX_THR:  shadow_cfg.max_thr  = data[THR_W-1:0];
      default:      shadow_cfg = shadow_cfg;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    reg_write(REG_GAIN,     c.gain);
    reg_write(REG_LOW_THR,  c.low_thr);
    reg_write(REG_HIGH_THR, c.high_thr);
    reg_write(REG_MIN_THR,  c.min_thr);
    reg_write(REG_MAX_THR,  c.max_thr);
  endtask

  // wait for all results, then let a trailing sample item finish
  task automatic settle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_throttle.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void add_sample(int value);
    speed_item_t it;
    it.operation    = OP_SAMPLE;
    it.speed_sample = SPEED_W'(value);
    it.set_speed    = $urandom;
    pending_items   = {pending_items, it};
  endfunction

  function automatic void add_target(int value);
    speed_item_t it;
    it.operation    = OP_TARGET;
    it.speed_sample = $urandom;
    it.set_speed    = TARGET_W'(value);
    pending_items   = {pending_items, it};
  endfunction

  function automatic int clamp_target(int v);
    return (v < 0) ? 0 : ((v > TARGET_MAX) ? TARGET_MAX : v);
  endfunction

  function automatic void add_random_item();
    int jitter;
    jitter = int'($urandom_range(0, 4)) - 2;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 3) == 0) add_sample($urandom);
      else add_sample(int'($urandom_range(0, 2000)) - 100);
    end else begin
      case ($urandom_range(0, 3))
        0: add_target(clamp_target(int'(BP_TABLE[$urandom_range(0, BP_COUNT - 1)]) + jitter));
        1: add_target(clamp_target(int'(shadow_cfg.low_thr) + jitter));
        2: add_target(clamp_target(int'(shadow_cfg.high_thr) + jitter));
        default: add_target($urandom_range(0, TARGET_MAX));
      endcase
    end
  endfunction

  initial begin
    cfg_t phase_cfg;
    clk                = 1'b0;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_SAMPLE;
    in_ch.speed_sample = '0;
    in_ch.set_speed    = '0;
    out_ch.ready       = 1'b0;
    shadow_cfg         = CFG_RST;
    avg_speed          = '0;
    foreach (speed_hist[k]) speed_hist[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: thresholds, breakpoints, both saturation directions
    add_target(0);
    add_target(26);
    add_target(128);
    add_target(333);
    add_target(1510);
    add_target(1511);
    add_target(TARGET_MAX);
    repeat (HISTORY_DEPTH) add_sample(4095);
    add_sample(-4096);
    add_target(0);
    settle();

    // gain off: exact 255 without clip, target past the last breakpoint
    phase_cfg = '{gain: 8'd0, low_thr: 11'd0, high_thr: 11'd2047,
                  min_thr: 8'd105, max_thr: 8'd0};
    apply_settings(phase_cfg);
    for (int k = REG_MAX_THR + 1; k < (1 << REG_IDX_W); k++)
      reg_write(REG_IDX_W'(k), $urandom);
    add_target(0);
    add_target(1800);
    settle();

    // low threshold above high threshold
    phase_cfg = '{gain: 8'd0, low_thr: 11'd1500, high_thr: 11'd100,
                  min_thr: 8'd30, max_thr: 8'd200};
    apply_settings(phase_cfg);
    add_target(1000);
    add_target(1600);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_cfg = CFG_RST;
        1: phase_cfg = '0;
        2: phase_cfg = '1;
        default: begin
          phase_cfg.gain     = $urandom;
          phase_cfg.low_thr  = $urandom_range(0, 400);
          phase_cfg.high_thr = $urandom_range(800, TARGET_MAX);
          phase_cfg.min_thr  = $urandom;
          phase_cfg.max_thr  = $urandom;
        end
      endcase
      apply_settings(phase_cfg);
      if (ph == STALL_PHASE) stall_requests++;
      repeat (PHASE_ITEMS) add_random_item();
      if (ph == PAUSE_PHASE) begin
        while (pending_items.size() > PHASE_ITEMS / 2) @(posedge clk);
        sender_hold = 1'b1;
        do @(posedge clk);
        while (in_ch.valid || expected_throttle.size() != 0);
        sender_hold = 1'b0;
      end
      settle();
    end

    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

@@ speed_throttle_controller_unit.f @@
design/stc_pkg.sv
design/stc_in_if.sv
design/stc_out_if.sv
design/stc_apb_regs.sv
design/stc_divider.sv
design/speed_throttle_controller_unit.sv
sim/testbench.sv
